// ===== design/plfs_pkg.sv =====
// Package for the priority link failover selector.
// Operation codes, register indexes, cell command types and field widths.
// No dependencies.
package plfs_pkg;

    localparam int OP_W    = 3;
    localparam int SLOT_W  = 3;
    localparam int PRIO_W  = 8;
    localparam int CNT_W   = 8;
    localparam int TOTAL_W = 16;
    localparam int MASK_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_REACH  = 3'd2,
        OP_HB     = 3'd3,
        OP_ACK    = 3'd4,
        OP_TERR   = 3'd5
    } t_op;

    typedef enum logic {
        CFG_ACK_LIMIT = 1'b0,
        CFG_HB_LIMIT  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FAIL_KEEP  = 2'd0,
        FAIL_CLEAR = 2'd1,
        FAIL_INC1  = 2'd2,
        FAIL_INC2  = 2'd3
    } t_fail_op;

    typedef enum logic [1:0] {
        ACK_KEEP  = 2'd0,
        ACK_CLEAR = 2'd1,
        ACK_LOAD  = 2'd2
    } t_ack_op;

    // Write command to the selected slot cell
    typedef struct packed {
        logic             set_pres;
        logic             clr_pres;
        logic             reach_wr;
        logic             reach_val;
        logic             prio_wr;
        t_fail_op         fail_op;
        t_ack_op          ack_op;
        logic [CNT_W-1:0] ack_val;
    } t_cell_cmd;

endpackage

// ===== design/plfs_if.sv =====
// Handshake channels of the priority link failover selector.
// Event channel and result channel; valid/ready with payload.
// Depends on nothing.
interface plfs_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [2:0] slot;
    logic [7:0] new_priority;
    logic       reachable_now;
    logic [7:0] timeout_count;

    modport source (output valid, operation, slot, new_priority, reachable_now,
                    timeout_count, input ready);
    modport sink   (input valid, operation, slot, new_priority, reachable_now,
                    timeout_count, output ready);
endinterface

interface plfs_res_if;
    logic        valid;
    logic        ready;
    logic        active_valid;
    logic [2:0]  active_slot;
    logic        switched;
    logic        all_unreachable;
    logic [7:0]  reachable_mask;
    logic [15:0] failover_total;

    modport source (output valid, active_valid, active_slot, switched, all_unreachable,
                    reachable_mask, failover_total, input ready);
    modport sink   (input valid, active_valid, active_slot, switched, all_unreachable,
                    reachable_mask, failover_total, output ready);
endinterface

// ===== design/plfs_cell.sv =====
// One endpoint slot of the selector: slot state plus one stage of the
// best-slot search chain. Depends on plfs_pkg.
module plfs_cell #(
    parameter int CELL_IDX = 0,
    parameter int PB       = 8,
    parameter int IW       = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_sel,
    input  plfs_pkg::t_cell_cmd       i_cmd,
    input  logic [PB-1:0]             i_prio,
    input  logic                      i_tok_found,
    input  logic [PB-1:0]             i_tok_prio,
    input  logic [IW-1:0]             i_tok_idx,
    output logic                      o_tok_found,
    output logic [PB-1:0]             o_tok_prio,
    output logic [IW-1:0]             o_tok_idx,
    output logic                      o_present,
    output logic                      o_reach,
    output logic [PB-1:0]             o_prio,
    output logic [plfs_pkg::CNT_W-1:0] o_fail
);
    import plfs_pkg::*;

    logic             r_pres, r_reach;
    logic [PB-1:0]    r_prio;
    logic [CNT_W-1:0] r_fail, r_ack;
    logic             r_tok_found;
    logic [PB-1:0]    r_tok_prio;
    logic [IW-1:0]    r_tok_idx;
    logic [CNT_W:0]   w_sum;
    logic [CNT_W-1:0] n_fail;
    logic             w_take;

    // saturating failure bump by one or two
    always_comb begin
        w_sum  = {1'b0, r_fail} + ((i_cmd.fail_op == FAIL_INC2) ? (CNT_W+1)'(2)
                                                                : (CNT_W+1)'(1));
        n_fail = w_sum[CNT_W] ? '1 : w_sum[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pres  <= 1'b0;
            r_reach <= 1'b0;
            r_ack   <= '0;
        end else if (i_sel) begin
            if (i_cmd.set_pres) r_pres <= 1'b1;
            else if (i_cmd.clr_pres) r_pres <= 1'b0;
            if (i_cmd.reach_wr) r_reach <= i_cmd.reach_val;
            case (i_cmd.ack_op)
                ACK_CLEAR: r_ack <= '0;
                ACK_LOAD:  r_ack <= i_cmd.ack_val;
                default:   r_ack <= r_ack;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sel) begin
            if (i_cmd.prio_wr) r_prio <= i_prio;
            case (i_cmd.fail_op)
                FAIL_CLEAR: r_fail <= '0;
                FAIL_INC1, FAIL_INC2: begin
                    if (r_pres) r_fail <= n_fail;
                end
                default: r_fail <= r_fail;
            endcase
        end
    end

    // search stage: lower slot keeps ties
    assign w_take = r_pres && r_reach && (!i_tok_found || (r_prio > i_tok_prio));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_found <= 1'b0;
        end else begin
            r_tok_found <= i_tok_found || w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_prio <= w_take ? r_prio : i_tok_prio;
        r_tok_idx  <= w_take ? IW'(CELL_IDX) : i_tok_idx;
    end

    assign o_tok_found = r_tok_found;
    assign o_tok_prio  = r_tok_prio;
    assign o_tok_idx   = r_tok_idx;
    assign o_present   = r_pres;
    assign o_reach     = r_reach;
    assign o_prio      = r_prio;
    assign o_fail      = r_fail;

endmodule

// ===== design/priority_link_failover_selector.sv =====
// Top level of the priority link failover selector: event sequencer, active
// selection registers and the row of slot cells. Depends on plfs_pkg, plfs_if
// and plfs_cell.
//
// Use: events enter on i_evt (valid/ready), one result beat per event leaves
// on o_res. Limits are written through i_cfg_we/i_cfg_idx/i_cfg_data while
// the block is idle (index 0 ack timeout limit, 1 heartbeat fail limit).
// One event is handled at a time. An event that needs no failover goes
// through the execute and done states to its result beat in the output
// register; an event that fails over also passes through the scan and
// apply states, the search passing one slot cell per cycle down the chain.
// A new event is accepted in the cycle after the previous result is loaded,
// even while that beat is still held.
// If the receiver stalls, the finished result waits in the output register
// and the sequencer holds its final state until the register frees.
// Reset clears slot presence, reachability and ack counts, the active
// selection and the failover count, and sets both limits to 3.
module priority_link_failover_selector #(
    parameter int NUM_SLOTS     = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    plfs_evt_if.sink   i_evt,
    plfs_res_if.source o_res,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import plfs_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int PB = PRIORITY_BITS;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_APPLY = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_ack_lim, r_hb_lim;
    logic [OP_W-1:0]  r_op;
    logic [SLOT_W-1:0] r_slot;
    logic [PB-1:0]    r_nprio;
    logic             r_rnow;
    logic [CNT_W-1:0] r_tcount;

    logic             r_valid, n_valid;
    logic [IW-1:0]    r_idx, n_idx;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic             r_old_valid;
    logic [IW-1:0]    r_old_idx;
    logic             r_flag, n_flag;
    logic             r_none, n_none;
    logic [IW-1:0]    r_cnt;

    logic             r_out_valid;
    logic             r_o_av, r_o_sw, r_o_none;
    logic [SLOT_W-1:0] r_o_slot;
    logic [MASK_W-1:0] r_o_mask;
    logic [TOTAL_W-1:0] r_o_total;

    t_cell_cmd        w_cmd;
    logic             w_cmd_en;
    logic [IW-1:0]    w_sel_idx;
    logic [IW-1:0]    w_s;
    logic             w_s_ok;

    logic             w_pres  [NUM_SLOTS];
    logic             w_reach [NUM_SLOTS];
    logic [PB-1:0]    w_prio  [NUM_SLOTS];
    logic [CNT_W-1:0] w_fail  [NUM_SLOTS];
    logic             w_tf    [NUM_SLOTS+1];
    logic [PB-1:0]    w_tp    [NUM_SLOTS+1];
    logic [IW-1:0]    w_ti    [NUM_SLOTS+1];
    logic [MASK_W-1:0] w_mask;

    logic             w_ps, w_rs, w_pa, w_act, w_beats;
    logic [PB-1:0]    w_prs, w_pra;
    logic [CNT_W:0]   w_f1sum;
    logic [CNT_W-1:0] w_f1;
    logic             w_out_free;

    assign w_s    = IW'(r_slot);
    assign w_s_ok = 32'(r_slot) < NUM_SLOTS;

    // slot cell row
    assign w_tf[0] = 1'b0;
    assign w_tp[0] = '0;
    assign w_ti[0] = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        plfs_cell #(.CELL_IDX(g), .PB(PB), .IW(IW)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_sel      (w_cmd_en && (w_sel_idx == IW'(g))),
            .i_cmd      (w_cmd),
            .i_prio     (r_nprio),
            .i_tok_found(w_tf[g]),
            .i_tok_prio (w_tp[g]),
            .i_tok_idx  (w_ti[g]),
            .o_tok_found(w_tf[g+1]),
            .o_tok_prio (w_tp[g+1]),
            .o_tok_idx  (w_ti[g+1]),
            .o_present  (w_pres[g]),
            .o_reach    (w_reach[g]),
            .o_prio     (w_prio[g]),
            .o_fail     (w_fail[g])
        );
    end

    for (genvar g = 0; g < MASK_W; g++) begin : g_mask
        if (g < NUM_SLOTS) begin : g_on
            assign w_mask[g] = w_pres[g] && w_reach[g];
        end else begin : g_off
            assign w_mask[g] = 1'b0;
        end
    end

    // views of the event slot and the active slot
    always_comb begin
        w_ps   = w_s_ok ? w_pres[w_s]  : 1'b0;
        w_rs   = w_s_ok ? w_reach[w_s] : 1'b0;
        w_prs  = w_s_ok ? w_prio[w_s]  : '0;
        w_f1sum = {1'b0, (w_s_ok ? w_fail[w_s] : '0)} + (CNT_W+1)'(1);
        w_f1   = w_f1sum[CNT_W] ? '1 : w_f1sum[CNT_W-1:0];
        w_pa   = w_pres[r_idx];
        w_pra  = w_prio[r_idx];
        w_act  = r_valid && (r_idx == w_s);
    end

    assign w_out_free = !r_out_valid || o_res.ready;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_idx     = r_idx;
        n_total   = r_total;
        n_flag    = r_flag;
        n_none    = r_none;
        w_cmd     = '0;
        w_cmd_en  = 1'b0;
        w_sel_idx = w_s;
        w_beats   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_evt.valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state  = ST_DONE;
                n_flag   = 1'b0;
                n_none   = 1'b0;
                w_cmd_en = w_s_ok;
                if (w_s_ok) begin
                    case (r_op)
                        OP_ADD: begin
                            w_cmd.set_pres = 1'b1;
                            w_cmd.reach_wr = 1'b1;
                            w_cmd.prio_wr  = 1'b1;
                            w_cmd.fail_op  = FAIL_CLEAR;
                            w_beats = !r_valid ||
                                      ((r_idx != w_s) && (!w_pa || (r_nprio > w_pra)));
                            if (w_beats) begin
                                w_cmd.reach_val = 1'b1;
                                w_cmd.ack_op    = ACK_CLEAR;
                                n_valid = 1'b1;
                                n_idx   = w_s;
                                if (!r_valid || r_idx != w_s) n_total = r_total + 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (w_ps) begin
                                w_cmd.clr_pres = 1'b1;
                                w_cmd.reach_wr = 1'b1;
                                w_cmd.ack_op   = ACK_CLEAR;
                                if (w_act) begin
                                    w_cmd.fail_op = FAIL_INC1;
                                    n_flag  = 1'b1;
                                    n_valid = 1'b0;
                                    n_state = ST_SCAN;
                                end
                            end
                        end
                        OP_REACH: begin
                            if (w_ps) begin
                                w_cmd.reach_wr  = 1'b1;
                                w_cmd.reach_val = r_rnow;
                                if (r_rnow && !w_rs) begin
                                    w_cmd.fail_op = FAIL_CLEAR;
                                    w_cmd.ack_op  = ACK_CLEAR;
                                    w_beats = !r_valid || !w_pa ||
                                              ((r_idx != w_s) && (w_prs > w_pra));
                                    if (w_beats) begin
                                        n_valid = 1'b1;
                                        n_idx   = w_s;
                                        if (!r_valid || r_idx != w_s)
                                            n_total = r_total + 1'b1;
                                    end
                                end else if (!r_rnow && w_rs) begin
                                    w_cmd.fail_op = FAIL_INC1;
                                    if (w_act) begin
                                        n_valid = 1'b0;
                                        n_state = ST_SCAN;
                                    end
                                end
                            end
                        end
                        OP_HB: begin
                            if (w_ps) begin
                                if (w_act) begin
                                    w_cmd.reach_wr = 1'b1;
                                    w_cmd.fail_op  = FAIL_INC2;
                                    n_flag  = 1'b1;
                                    n_valid = 1'b0;
                                    n_state = ST_SCAN;
                                end else if (w_f1 >= r_hb_lim) begin
                                    w_cmd.reach_wr = 1'b1;
                                    w_cmd.fail_op  = FAIL_INC2;
                                end else begin
                                    w_cmd.fail_op  = FAIL_INC1;
                                end
                            end
                        end
                        OP_ACK: begin
                            w_cmd.ack_op  = ACK_LOAD;
                            w_cmd.ack_val = r_tcount;
                            if ((r_tcount >= r_ack_lim) && w_act) begin
                                w_cmd.reach_wr = 1'b1;
                                w_cmd.fail_op  = FAIL_INC1;
                                n_flag  = 1'b1;
                                n_valid = 1'b0;
                                n_state = ST_SCAN;
                            end
                        end
                        OP_TERR: begin
                            if (w_ps) begin
                                // bump, then mark unreachable: two steps on the count
                                w_cmd.reach_wr = 1'b1;
                                w_cmd.fail_op  = FAIL_INC2;
                                if (w_act) begin
                                    n_flag  = 1'b1;
                                    n_valid = 1'b0;
                                    n_state = ST_SCAN;
                                end
                            end
                        end
                        default: w_cmd = '0;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_cnt == IW'(NUM_SLOTS-1)) n_state = ST_APPLY;
            end
            ST_APPLY: begin
                n_state   = ST_DONE;
                w_sel_idx = w_ti[NUM_SLOTS];
                if (w_tf[NUM_SLOTS]) begin
                    w_cmd_en        = 1'b1;
                    w_cmd.reach_wr  = 1'b1;
                    w_cmd.reach_val = 1'b1;
                    w_cmd.fail_op   = FAIL_CLEAR;
                    w_cmd.ack_op    = ACK_CLEAR;
                    n_valid = 1'b1;
                    n_idx   = w_ti[NUM_SLOTS];
                    n_total = r_total + 1'b1;
                end else begin
                    n_none = r_flag;
                end
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_evt.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= 1'b0;
            r_idx     <= '0;
            r_total   <= '0;
            r_flag    <= 1'b0;
            r_none    <= 1'b0;
            r_cnt     <= '0;
            r_ack_lim <= CNT_W'(3);
            r_hb_lim  <= CNT_W'(3);
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
            r_total <= n_total;
            r_flag  <= n_flag;
            r_none  <= n_none;
            r_cnt   <= (r_state == ST_SCAN) ? r_cnt + 1'b1 : '0;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ACK_LIMIT: r_ack_lim <= i_cfg_data;
                    CFG_HB_LIMIT:  r_hb_lim  <= i_cfg_data;
                    default:       r_ack_lim <= r_ack_lim;
                endcase
            end
        end
    end

    // event beat capture and selection before the event
    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_op     <= i_evt.operation;
            r_slot   <= i_evt.slot;
            r_nprio  <= PB'(i_evt.new_priority);
            r_rnow   <= i_evt.reachable_now;
            r_tcount <= i_evt.timeout_count;
        end
        if (r_state == ST_EXEC) begin
            r_old_valid <= r_valid;
            r_old_idx   <= r_idx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_o_av    <= r_valid;
            r_o_slot  <= r_valid ? SLOT_W'(r_idx) : '0;
            r_o_sw    <= (r_old_valid != r_valid) || (r_valid && (r_old_idx != r_idx));
            r_o_none  <= r_none;
            r_o_mask  <= w_mask;
            r_o_total <= r_total;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.active_valid    = r_o_av;
    assign o_res.active_slot     = r_o_slot;
    assign o_res.switched        = r_o_sw;
    assign o_res.all_unreachable = r_o_none;
    assign o_res.reachable_mask  = r_o_mask;
    assign o_res.failover_total  = r_o_total;

endmodule

// ===== tb/sv/plfs_checker.sv =====
// Scoreboard for the priority link failover selector: watches the event and
// result channels, predicts each result beat and compares field by field.
// Depends on plfs_pkg and plfs_if.
module plfs_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plfs_evt_if.sink  i_evt_mon,
    plfs_res_if.sink  i_res_mon,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import plfs_pkg::*;

    localparam int N = 8;

    typedef struct packed {
        logic        active_valid;
        logic [2:0]  active_slot;
        logic        switched;
        logic        all_unreachable;
        logic [7:0]  reachable_mask;
        logic [15:0] failover_total;
    } t_status;

    logic [7:0]  ack_limit, hb_limit;
    logic        present   [N];
    logic        reach     [N];
    logic [7:0]  prio      [N];
    logic [7:0]  fails     [N];
    logic [7:0]  acks      [N];
    logic        act_valid;
    logic [2:0]  act_idx;
    logic [15:0] switch_count;

    t_status expected_status [$];

    function automatic int pick_best();
        int best;
        best = -1;
        for (int i = 0; i < N; i++)
            if (present[i] && reach[i])
                if (best < 0 || prio[i] > prio[best])
                    best = i;
        return best;
    endfunction

    task automatic take_slot(input int s);
        logic changed;
        changed = !act_valid || act_idx != s[2:0];
        act_valid = 1'b1;
        act_idx   = s[2:0];
        if (present[s]) begin
            reach[s] = 1'b1;
            fails[s] = 8'd0;
            acks[s]  = 8'd0;
        end
        if (changed)
            switch_count = switch_count + 16'd1;
    endtask

    task automatic bump(input int s);
        if (fails[s] != 8'hFF)
            fails[s] = fails[s] + 8'd1;
    endtask

    function automatic logic is_act(input int s);
        return act_valid && act_idx == s[2:0];
    endfunction

    task automatic drop_slot(input int s);
        int b;
        if (present[s]) begin
            reach[s] = 1'b0;
            bump(s);
        end
        if (is_act(s)) begin
            act_valid = 1'b0;
            b = pick_best();
            if (b >= 0)
                take_slot(b);
        end
    endtask

    function automatic logic outranks(input int s);
        if (!act_valid || !present[act_idx])
            return 1'b1;
        return prio[s] > prio[act_idx];
    endfunction

    task automatic fail_over(output logic none);
        int b;
        if (act_valid)
            drop_slot(act_idx);
        b = pick_best();
        none = 1'b0;
        if (b >= 0) begin
            take_slot(b);
        end else begin
            act_valid = 1'b0;
            none = 1'b1;
        end
    endtask

    task automatic predict_event(input t_op op, input int s, input logic [7:0] np,
                                 input logic rn, input logic [7:0] tc);
        logic    old_v, pres, was, none;
        logic [2:0] old_i;
        t_status r;
        old_v = act_valid;
        old_i = act_idx;
        none  = 1'b0;
        pres  = present[s];
        case (op)
            OP_ADD: begin
                present[s] = 1'b1;
                reach[s]   = 1'b0;
                prio[s]    = np;
                fails[s]   = 8'd0;
                if (outranks(s))
                    take_slot(s);
            end
            OP_REMOVE: begin
                if (pres) begin
                    if (is_act(s))
                        fail_over(none);
                    present[s] = 1'b0;
                    reach[s]   = 1'b0;
                    acks[s]    = 8'd0;
                end
            end
            OP_REACH: begin
                if (pres) begin
                    was = reach[s];
                    reach[s] = rn;
                    if (rn && !was) begin
                        fails[s] = 8'd0;
                        acks[s]  = 8'd0;
                        if (outranks(s))
                            take_slot(s);
                    end else if (!rn && was) begin
                        drop_slot(s);
                    end
                end
            end
            OP_HB: begin
                if (pres) begin
                    bump(s);
                    if (is_act(s))
                        fail_over(none);
                    else if (fails[s] >= hb_limit)
                        drop_slot(s);
                end
            end
            OP_ACK: begin
                acks[s] = tc;
                if (tc >= ack_limit && is_act(s))
                    fail_over(none);
            end
            OP_TERR: begin
                if (pres) begin
                    bump(s);
                    if (is_act(s))
                        fail_over(none);
                    else
                        drop_slot(s);
                end
            end
            default: ;
        endcase
        r.reachable_mask = '0;
        for (int i = 0; i < N; i++)
            r.reachable_mask[i] = present[i] && reach[i];
        r.active_valid    = act_valid;
        r.active_slot     = act_valid ? act_idx : 3'd0;
        r.switched        = (old_v != act_valid) || (act_valid && old_i != act_idx);
        r.all_unreachable = none;
        r.failover_total  = switch_count;
        expected_status.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_status got, want;
        if (!i_rst_n) begin
            ack_limit      <= 8'd3;
            hb_limit       <= 8'd3;
            o_fail_count   <= 0;
            o_results_seen <= 0;
            act_valid    = 1'b0;
            act_idx      = 3'd0;
            switch_count = 16'd0;
            for (int i = 0; i < N; i++) begin
                present[i] = 1'b0;
                reach[i]   = 1'b0;
                prio[i]    = 8'd0;
                fails[i]   = 8'd0;
                acks[i]    = 8'd0;
            end
            expected_status.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ACK_LIMIT)
                    ack_limit <= i_cfg_data;
                else
                    hb_limit <= i_cfg_data;
            end
            if (i_evt_mon.valid && i_evt_mon.ready)
                predict_event(t_op'(i_evt_mon.operation), int'(i_evt_mon.slot),
                              i_evt_mon.new_priority, i_evt_mon.reachable_now,
                              i_evt_mon.timeout_count);
            if (i_res_mon.valid && i_res_mon.ready) begin
                got.active_valid    = i_res_mon.active_valid;
                got.active_slot     = i_res_mon.active_slot;
                got.switched        = i_res_mon.switched;
                got.all_unreachable = i_res_mon.all_unreachable;
                got.reachable_mask  = i_res_mon.reachable_mask;
                got.failover_total  = i_res_mon.failover_total;
                o_results_seen <= o_results_seen + 1;
                if (expected_status.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat: %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_status.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("result %0d: expected %p, got %p",
                                     o_results_seen, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = expected_status.size();
endmodule

// ===== tb/sv/priority_link_failover_selector_test.sv =====
// Top of the priority link failover selector testbench: clock, reset,
// event and limit stimulus, result back-pressure and the verdict.
// Depends on plfs_pkg, plfs_if, plfs_checker and the block.
module priority_link_failover_selector_test;
    timeunit 1ns;
    timeprecision 1ps;
    import plfs_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_idx = CFG_ACK_LIMIT;
    logic [7:0] cfg_data = 8'd0;
    int         fail_count, pending, results_seen;
    int         idle_cycles = 0;
    bit         hold_res = 1'b0;
    int         events_sent = 0;

    plfs_evt_if evt ();
    plfs_res_if res ();

    priority_link_failover_selector dut (
        .i_clk, .i_rst_n, .i_evt(evt.sink), .o_res(res.source),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    plfs_checker scoreboard (
        .i_clk, .i_rst_n, .i_evt_mon(evt.sink), .i_res_mon(res.sink),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one beat and hold it until taken. Valid drops only when a gap
    // follows; with no gap the next call overwrites the payload in place.
    task automatic send_event(input t_op op, input logic [2:0] s, input logic [7:0] np,
                              input logic rn, input logic [7:0] tc);
        int g;
        evt.valid         <= 1'b1;
        evt.operation     <= op;
        evt.slot          <= s;
        evt.new_priority  <= np;
        evt.reachable_now <= rn;
        evt.timeout_count <= tc;
        do @(posedge i_clk); while (!(evt.ready === 1'b1));
        @(negedge i_clk);
        events_sent++;
        g = gap_len();
        if (g > 0) begin
            evt.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        evt.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_limits(input logic [7:0] ack_v, input logic [7:0] hb_v);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ACK_LIMIT;
        cfg_data <= ack_v;
        @(negedge i_clk);
        cfg_idx  <= CFG_HB_LIMIT;
        cfg_data <= hb_v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_event(input int heavy);
        t_op        op;
        logic [2:0] s;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 20)      op = OP_ADD;
        else if (r < 30) op = OP_REMOVE;
        else if (r < 55) op = OP_REACH;
        else if (r < 70) op = OP_HB;
        else if (r < 85) op = OP_ACK;
        else             op = OP_TERR;
        s = heavy ? 3'($urandom_range(0, 3)) : 3'($urandom_range(0, 7));
        send_event(op, s, 8'($urandom), 1'($urandom_range(0, 99) < 70),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)));
    endtask

    // Result side back-pressure, with one long hold-off while events keep coming.
    always @(negedge i_clk) begin
        if (hold_res)
            res.ready <= 1'b0;
        else
            res.ready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge i_clk) begin
        if ((evt.valid && evt.ready) || (res.valid && res.ready) || !i_rst_n || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog expired, %0d beats outstanding", pending);
            $display("priority_link_failover_selector: mismatch");
            $finish;
        end
    end

    initial begin
        logic [7:0] limit_sets [4][2];
        limit_sets = '{'{8'd1, 8'd1}, '{8'd255, 8'd255}, '{8'd2, 8'd5}, '{8'd3, 8'd3}};
        evt.valid = 1'b0;
        evt.operation = OP_ADD;
        evt.slot = '0;
        evt.new_priority = '0;
        evt.reachable_now = 1'b0;
        evt.timeout_count = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty table, adds at both priority extremes, ties, every op.
        send_event(OP_HB, 3'd2, 8'd0, 1'b0, 8'd0);
        send_event(OP_ACK, 3'd6, 8'd0, 1'b0, 8'd255);
        send_event(t_op'(3'd6), 3'd1, 8'hFF, 1'b1, 8'hFF);
        send_event(t_op'(3'd7), 3'd7, 8'h00, 1'b0, 8'h00);
        send_event(OP_ADD, 3'd0, 8'd0, 1'b0, 8'd0);
        send_event(OP_ADD, 3'd7, 8'd255, 1'b1, 8'd0);
        send_event(OP_ADD, 3'd3, 8'd255, 1'b0, 8'd0);
        send_event(OP_REACH, 3'd3, 8'd0, 1'b1, 8'd0);
        send_event(OP_REACH, 3'd0, 8'd0, 1'b1, 8'd0);
        send_event(OP_REACH, 3'd0, 8'd0, 1'b1, 8'd0);
        send_event(OP_ACK, 3'd7, 8'd0, 1'b0, 8'd3);
        send_event(OP_HB, 3'd3, 8'd0, 1'b0, 8'd0);
        send_event(OP_HB, 3'd0, 8'd0, 1'b0, 8'd0);
        send_event(OP_TERR, 3'd3, 8'd0, 1'b0, 8'd0);
        send_event(OP_REACH, 3'd0, 8'd0, 1'b1, 8'd0);
        send_event(OP_REACH, 3'd0, 8'd0, 1'b0, 8'd0);
        send_event(OP_ADD, 3'd5, 8'd128, 1'b0, 8'd0);
        send_event(OP_ADD, 3'd5, 8'd1, 1'b0, 8'd0);
        send_event(OP_REMOVE, 3'd5, 8'd0, 1'b0, 8'd0);
        send_event(OP_REMOVE, 3'd4, 8'd0, 1'b0, 8'd0);
        send_event(OP_TERR, 3'd1, 8'd0, 1'b0, 8'd0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_limits(limit_sets[ph][0], limit_sets[ph][1]);
            if (ph == 1) begin
                fork
                    begin
                        hold_res = 1'b1;
                        repeat (300) @(negedge i_clk);
                        hold_res = 1'b0;
                    end
                    repeat (10) random_event(1);
                join
            end
            for (int k = 0; k < 108; k++) begin
                // Keep slots populated and reachable so failover paths get exercised.
                if ($urandom_range(0, 3) == 0)
                    send_event(OP_ADD, 3'($urandom_range(0, 7)), 8'($urandom), 1'b0, 8'd0);
                else if ($urandom_range(0, 3) == 0)
                    send_event(OP_REACH, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 3)),
                               1'b1, 8'd0);
                else
                    random_event(k % 3 == 0);
            end
            // Sender pause: everything in flight must come back first.
            wait_drained();
        end
        $display("%0d events driven, %0d results checked across four limit settings",
                 events_sent, results_seen);
        if (fail_count == 0)
            $display("priority_link_failover_selector: match");
        else
            $display("priority_link_failover_selector: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
design/plfs_pkg.sv
design/plfs_if.sv
design/plfs_cell.sv
design/priority_link_failover_selector.sv
tb/sv/plfs_checker.sv
tb/sv/priority_link_failover_selector_test.sv
